// File: rtl/plrf_pkg.sv
package plrf_pkg;

    // Ring size default
    localparam int BUFFER_BYTES_DEF = 32768;

    // Field widths
    localparam int PERIOD_W   = 13;
    localparam int BEAT_W     = 3;
    localparam int RATE_W     = 18;
    localparam int OFFS_W     = 15;
    localparam int COUNT_W    = 15;
    localparam int LEN_W      = 13;
    localparam int FREE_W     = 16;
    localparam int WPOS_W     = 15;
    localparam int WORD_W     = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 64;

    // Width of a raw read position (beat size times beat count) before reduction
    localparam int X_W = 18;

    // Register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RST  = PERIOD_W'(192);
    localparam logic [BEAT_W-1:0]   BEAT_RST    = BEAT_W'(2);
    localparam logic [RATE_W-1:0]   NOMINAL_RST = RATE_W'(48000);
    localparam logic [OFFS_W-1:0]   OFFS_RST    = OFFS_W'(384);

    // Feedback word: 10.14 kHz format, rate/1000 and rate%1000
    localparam int FB_RATE_W = 19;
    localparam int FB_M_W    = 20;
    localparam int FB_P_W    = FB_RATE_W + FB_M_W;
    localparam int FB_SH     = 29;
    localparam int FB_Q_W    = 9;
    localparam int FB_R_W    = 10;
    localparam int FB_Q_POS  = 14;
    localparam int FB_R_POS  = 4;
    localparam logic [FB_M_W-1:0]    FB_MUL = FB_M_W'(64'(64'd1 << FB_SH) / 64'd1000);
    localparam logic [FB_RATE_W-1:0] FB_DIV = FB_RATE_W'(1000);

    typedef enum logic [1:0] {
        OP_PACKET = 2'd0,
        OP_TICK   = 2'd1,
        OP_START  = 2'd2,
        OP_STOP   = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD  = 2'd0,
        CFG_BEAT    = 2'd1,
        CFG_NOMINAL = 2'd2,
        CFG_OFFSET  = 2'd3
    } t_cfg_idx;

    // Rate controller modes
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_SLOW   = 3'b010,
        MODE_FAST   = 3'b100
    } t_mode;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [BEAT_W-1:0]   beat;
        logic [RATE_W-1:0]   nominal;
        logic [OFFS_W-1:0]   offs;
    } t_cfg;

    // Item fields travelling alongside the read position
    typedef struct packed {
        t_op              op;
        logic [LEN_W-1:0] len;
        logic             busy;
    } t_item;

    // Result of the state stage, before the feedback word is encoded
    typedef struct packed {
        logic [FREE_W-1:0]    free;
        logic                 over;
        logic                 under;
        logic [WPOS_W-1:0]    wpos;
        logic                 fbv;
        logic [FB_RATE_W-1:0] rate;
    } t_result;

endpackage

// File: rtl/plrf_modred.sv
module plrf_modred
    import plrf_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_vld,
    input  logic [X_W-1:0]                  i_x,
    input  t_item                           i_item,
    output logic                            o_vld,
    output logic [$clog2(BUFFER_BYTES)-1:0] o_pos,
    output t_item                           o_item
);

    localparam int P_W    = $clog2(BUFFER_BYTES);
    localparam int SH     = 32;
    localparam int M_W    = 34 - P_W;
    localparam int Q_W    = X_W + 1 - P_W;
    localparam int PROD_W = X_W + M_W;
    localparam logic [M_W-1:0] MUL = M_W'(64'(64'd1 << SH) / 64'(BUFFER_BYTES));
    localparam logic [X_W-1:0] B_X = X_W'(BUFFER_BYTES);

    logic              r_a_vld, r_b_vld, r_c_vld;
    logic [X_W-1:0]    r_a_x, r_b_x;
    t_item             r_a_item, r_b_item, r_c_item;
    logic [Q_W-1:0]    r_b_q;
    logic [P_W-1:0]    r_c_pos;
    logic [PROD_W-1:0] w_prod;
    logic [X_W-1:0]    w_qb, w_r, w_pos;

    // Quotient estimate by reciprocal, low by at most one
    assign w_prod = r_a_x * MUL;

    // Remainder with one correction step
    assign w_qb  = X_W'(r_b_q) * B_X;
    assign w_r   = r_b_x - w_qb;
    assign w_pos = (w_r >= B_X) ? w_r - B_X : w_r;

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_x    <= i_x;
            r_a_item <= i_item;
            r_b_q    <= w_prod[SH +: Q_W];
            r_b_x    <= r_a_x;
            r_b_item <= r_a_item;
            r_c_pos  <= P_W'(w_pos);
            r_c_item <= r_b_item;
        end
    end

    assign o_vld  = r_c_vld;
    assign o_pos  = r_c_pos;
    assign o_item = r_c_item;

endmodule

// File: rtl/plrf_core.sv
module plrf_core
    import plrf_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_vld,
    input  logic [$clog2(BUFFER_BYTES)-1:0] i_pos,
    input  t_item                           i_item,
    input  logic [PERIOD_W-1:0]             i_period,
    input  logic [RATE_W-1:0]               i_nominal,
    output logic                            o_vld,
    output t_result                         o_res
);

    localparam int P_W = $clog2(BUFFER_BYTES);
    localparam int C_W = $clog2(BUFFER_BYTES + 1);
    localparam int G_W = C_W + 1;
    localparam logic [G_W-1:0] B_G       = G_W'(BUFFER_BYTES);
    localparam logic [C_W-1:0] B_C       = C_W'(BUFFER_BYTES);
    localparam logic [C_W-1:0] TH_FAST   = C_W'(BUFFER_BYTES * 3 / 4);
    localparam logic [C_W-1:0] TH_SLOW   = C_W'(BUFFER_BYTES / 4);
    localparam logic [C_W-1:0] TH_SLOW_X = C_W'(BUFFER_BYTES * 3 / 5);
    localparam logic [C_W-1:0] TH_FAST_X = C_W'(BUFFER_BYTES / 2);

    logic           r_playing, n_playing;
    logic [P_W-1:0] r_wp, n_wp;
    logic           r_under, n_under;
    t_mode          r_mode, n_mode;
    logic           r_vld;
    t_result        r_res, n_res;

    logic [G_W-1:0]       w_wp, w_rp, w_wrap, w_gap, w_sum, w_sum_wr;
    logic [C_W-1:0]       w_free, w_fb_free;
    logic [PERIOD_W-1:0]  w_half;
    logic                 w_over;
    logic [FB_RATE_W-1:0] w_nom, w_low, w_high;

    // Free space and fill gap against the read position
    assign w_wp   = G_W'(r_wp);
    assign w_rp   = G_W'(i_pos);
    assign w_wrap = B_G - w_wp + w_rp;
    always_comb begin
        if (w_wp > w_rp) begin
            w_free = C_W'(w_wrap);
            w_gap  = w_wp - w_rp;
        end else if (w_wp == w_rp) begin
            w_free = B_C;
            w_gap  = B_G;
        end else begin
            w_free = C_W'(w_rp - w_wp);
            w_gap  = w_wrap;
        end
    end

    assign w_over    = (32'(w_free) <= 32'(i_item.len));
    assign w_fb_free = w_over ? '0 : w_free;
    assign w_half    = i_period >> 1;
    // Only used when the chunk fits, so the chunk is below the ring size
    assign w_sum     = w_wp + G_W'(i_item.len);
    assign w_sum_wr  = (w_sum >= B_G) ? w_sum - B_G : w_sum;

    // Candidate feedback rates
    assign w_nom  = FB_RATE_W'(i_nominal);
    assign w_low  = w_nom - FB_RATE_W'(i_nominal >> 3);
    assign w_high = w_nom + FB_RATE_W'(i_nominal >> 2);

    // Next state and result
    always_comb begin
        n_playing = r_playing;
        n_wp      = r_wp;
        n_under   = r_under;
        n_mode    = r_mode;
        n_res     = '0;
        case (i_item.op)
            OP_PACKET: begin
                if (r_playing) begin
                    n_res.over = w_over;
                    if (!w_over) begin
                        if (32'(w_gap) < 32'(w_half)) begin
                            n_under = 1'b1;
                        end else if (32'(w_gap) >= 32'(i_period)) begin
                            n_under = 1'b0;
                        end
                        n_wp       = P_W'(w_sum_wr);
                        n_res.free = (32'(w_free) > 32'd65535) ? '1 : FREE_W'(w_free);
                    end
                    if (!i_item.busy) begin
                        n_res.fbv = 1'b1;
                        unique case (r_mode)
                            MODE_NORMAL: begin
                                n_res.rate = w_nom;
                                if (w_fb_free >= TH_FAST) begin
                                    n_mode = MODE_FAST;
                                end else if (w_fb_free <= TH_SLOW) begin
                                    n_mode = MODE_SLOW;
                                end
                            end
                            MODE_SLOW: begin
                                n_res.rate = w_low;
                                if (w_fb_free >= TH_SLOW_X) begin
                                    n_mode = MODE_NORMAL;
                                end
                            end
                            MODE_FAST: begin
                                n_res.rate = w_high;
                                if (w_fb_free <= TH_FAST_X) begin
                                    n_mode = MODE_NORMAL;
                                end
                            end
                            default: begin
                                n_res.rate = w_nom;
                            end
                        endcase
                    end
                end
            end
            OP_TICK: begin
                if (r_playing && (32'(w_gap) < 32'(w_half))) begin
                    n_under = 1'b1;
                end
            end
            OP_START: begin
                n_playing = 1'b1;
                n_wp      = i_pos;
                n_under   = 1'b0;
                n_mode    = MODE_NORMAL;
            end
            default: begin
                // stop: rate mode is kept
                n_playing = 1'b0;
                n_wp      = '0;
                n_under   = 1'b0;
            end
        endcase
        n_res.under = n_under;
        n_res.wpos  = WPOS_W'(n_wp);
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing <= 1'b0;
            r_wp      <= '0;
            r_under   <= 1'b0;
            r_mode    <= MODE_NORMAL;
            r_vld     <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
            if (i_vld) begin
                r_playing <= n_playing;
                r_wp      <= n_wp;
                r_under   <= n_under;
                r_mode    <= n_mode;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_vld = r_vld;
    assign o_res = r_res;

endmodule

// File: rtl/plrf_fbenc.sv
module plrf_fbenc
    import plrf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  t_result           i_res,
    output logic              o_vld,
    output t_result           o_res,
    output logic [WORD_W-1:0] o_word
);

    logic                 r_a_vld, r_o_vld;
    t_result              r_a_res, r_o_res;
    logic [FB_Q_W-1:0]    r_a_q;
    logic [WORD_W-1:0]    r_o_word;
    logic [FB_P_W-1:0]    w_prod;
    logic [FB_RATE_W-1:0] w_rem, w_rem_c;
    logic [FB_Q_W-1:0]    w_q_c;
    logic [WORD_W-1:0]    w_word;

    // kHz part by reciprocal, low by at most one
    assign w_prod = i_res.rate * FB_MUL;

    // Remainder and correction, then pack 10.14
    assign w_rem   = r_a_res.rate - FB_RATE_W'(r_a_q) * FB_DIV;
    assign w_rem_c = (w_rem >= FB_DIV) ? w_rem - FB_DIV : w_rem;
    assign w_q_c   = (w_rem >= FB_DIV) ? r_a_q + FB_Q_W'(1) : r_a_q;
    assign w_word  = r_a_res.fbv
                   ? ((WORD_W'(w_q_c) << FB_Q_POS) | (WORD_W'(w_rem_c[FB_R_W-1:0]) << FB_R_POS))
                   : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_o_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_res  <= i_res;
            r_a_q    <= w_prod[FB_SH +: FB_Q_W];
            r_o_res  <= r_a_res;
            r_o_word <= w_word;
        end
    end

    assign o_vld  = r_o_vld;
    assign o_res  = r_o_res;
    assign o_word = r_o_word;

endmodule

// File: rtl/playback_ring_level_feedback_unit.sv
// Playback ring level and feedback rate tracker.
// Input stream: one beat per event. tuser carries the operation (packet,
// tick, start, stop); tdata carries read_count, chunk_len and feedback_busy.
// Output stream: exactly one result beat per input beat, in order, with
// free space, overrun, underrun, write position and the 10.14 feedback word.
// Configuration: a separate write channel (index, data), always ready; write
// it only while no item is in flight.
// Pipeline: an input register, three stages of read position reduction modulo
// the ring size (reciprocal multiply and one correction), the state stage, and
// two stages turning the rate into kHz integer and fraction.
// Throughput: one beat per cycle while the output is not held; the ring state
// closes its loop in the single state stage, so back to back beats need no spacing.
// Reset clears the pipeline, the state (not playing, pointer 0, normal
// rate mode) and loads the register defaults.
// When the output is held by a low tready the whole pipeline holds and
// tready on the input stays low for as long as the output beat is held.
module playback_ring_level_feedback_unit
    import plrf_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,  // read_count[14:0], chunk_len[27:15], feedback_busy[28]
    input  logic [S_TUSER_W-1:0]  i_s_tuser,  // operation[1:0]
    // output stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,  // free_bytes[15:0], overrun[16], underrun[17],
                                              // write_position[32:18], feedback_valid[33],
                                              // feedback_word[57:34]
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int P_W = $clog2(BUFFER_BYTES);

    t_cfg                r_cfg;
    logic                r_in_vld;
    t_item               r_in_item;
    logic [COUNT_W-1:0]  r_in_count;
    logic                w_en;
    logic [X_W-1:0]      w_rp_raw, w_x;
    logic                w_mr_vld, w_core_vld;
    logic [P_W-1:0]      w_mr_pos;
    t_item               w_mr_item;
    t_result             w_core_res, w_out_res;
    logic [WORD_W-1:0]   w_out_word;

    // Whole pipeline advances unless the output beat is held
    assign w_en        = !o_m_tvalid || i_m_tready;
    assign o_s_tready  = w_en;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period  <= PERIOD_RST;
            r_cfg.beat    <= BEAT_RST;
            r_cfg.nominal <= NOMINAL_RST;
            r_cfg.offs    <= OFFS_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PERIOD:  r_cfg.period  <= i_cfg_data[PERIOD_W-1:0];
                CFG_BEAT:    r_cfg.beat    <= i_cfg_data[BEAT_W-1:0];
                CFG_NOMINAL: r_cfg.nominal <= i_cfg_data[RATE_W-1:0];
                CFG_OFFSET:  r_cfg.offs    <= i_cfg_data[OFFS_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_en) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_count     <= i_s_tdata[COUNT_W-1:0];
            r_in_item.len  <= i_s_tdata[COUNT_W +: LEN_W];
            r_in_item.busy <= i_s_tdata[COUNT_W + LEN_W];
            r_in_item.op   <= t_op'(i_s_tuser);
        end
    end

    // Raw position: start offset on start, otherwise beats times beat size
    assign w_rp_raw = X_W'(r_cfg.beat) * X_W'(r_in_count);
    assign w_x      = (r_in_item.op == OP_START) ? X_W'(r_cfg.offs) : w_rp_raw;

    plrf_modred #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_modred (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_in_vld),
        .i_x     (w_x),
        .i_item  (r_in_item),
        .o_vld   (w_mr_vld),
        .o_pos   (w_mr_pos),
        .o_item  (w_mr_item)
    );

    plrf_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_vld     (w_mr_vld),
        .i_pos     (w_mr_pos),
        .i_item    (w_mr_item),
        .i_period  (r_cfg.period),
        .i_nominal (r_cfg.nominal),
        .o_vld     (w_core_vld),
        .o_res     (w_core_res)
    );

    plrf_fbenc u_fbenc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_core_vld),
        .i_res   (w_core_res),
        .o_vld   (o_m_tvalid),
        .o_res   (w_out_res),
        .o_word  (w_out_word)
    );

    // Output beat packing, first field lowest
    assign o_m_tdata = {6'd0, w_out_word, w_out_res.fbv, w_out_res.wpos,
                        w_out_res.under, w_out_res.over, w_out_res.free};

endmodule

// File: rtl/plrf_checker.sv
module plrf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata
);

    localparam int OVER_BIT = 16;
    localparam int FBV_BIT  = 33;

    // Output register empties on reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // A held beat keeps its contents
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("held output beat changed");

    // Input side never blocks while the output register can move
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("input stalled with output free");

    // A rejected packet reports no free space
    a_over_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[OVER_BIT] |-> o_m_tdata[15:0] == 16'd0)
        else $error("overrun with non-zero free space");

    // No feedback word without feedback valid
    a_fb_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[FBV_BIT] |-> o_m_tdata[57:34] == 24'd0)
        else $error("feedback word without feedback valid");

endmodule

bind playback_ring_level_feedback_unit plrf_checker u_plrf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// File: tb/sv/tb_playback_ring_level_feedback_unit.sv
`timescale 1ns / 1ps

module tb_playback_ring_level_feedback_unit;
    import plrf_pkg::*;

    localparam int unsigned RING_BYTES  = BUFFER_BYTES_DEF;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_AT     = 620;
    localparam int unsigned HOLD_CYCLES = 250;
    localparam int unsigned STEADY_FROM = 250;
    localparam int unsigned STEADY_TO   = 500;
    localparam int unsigned N_PHASES    = 8;

    // One event beat as it travels in: op in tuser, the rest in tdata
    typedef struct packed {
        t_op               op;
        logic              busy;
        logic [LEN_W-1:0]  len;
        logic [COUNT_W-1:0] count;
    } ring_item_t;

    // Result beat, laid out exactly as the low 58 bits of the output tdata
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              fbv;
        logic [WPOS_W-1:0] wpos;
        logic              under;
        logic              over;
        logic [FREE_W-1:0] free;
    } ring_result_t;

    typedef struct packed {
        logic              playing;
        t_mode             mode;
        logic              under;
        logic [WPOS_W-1:0] wp;
    } ring_state_t;

    localparam ring_state_t RING_IDLE = '{playing: 1'b0, mode: MODE_NORMAL,
                                          under: 1'b0, wp: '0};

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_valid   = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_ready   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    wire                   s_ready;
    wire                   m_valid;
    wire [M_TDATA_W-1:0]   m_tdata;
    wire                   cfg_ready;

    // Register copies used for the level prediction
    logic [PERIOD_W-1:0] cfg_period  = PERIOD_RST;
    logic [BEAT_W-1:0]   cfg_beat    = BEAT_RST;
    logic [RATE_W-1:0]   cfg_nominal = NOMINAL_RST;
    logic [OFFS_W-1:0]   cfg_offset  = OFFS_RST;

    ring_state_t  ring_st;      // advanced on accepted beats
    ring_state_t  gen_st;       // advanced as stimulus is queued, to aim fills
    ring_item_t   ring_ops_q[$];
    ring_result_t level_reports_q[$];

    int unsigned n_queued = 0;
    int unsigned n_acc    = 0;
    int unsigned n_chk    = 0;
    int unsigned n_err    = 0;
    int unsigned n_cyc    = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned n_over = 0, n_under = 0, n_fb = 0, n_fb_slow = 0, n_fb_fast = 0;

    playback_ring_level_feedback_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (s_ready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Ring level tracker: pointer, underrun hysteresis and feedback rate
    function automatic ring_result_t ring_advance(input ring_item_t it,
                                                  inout ring_state_t st);
        ring_result_t r;
        int unsigned  rp, wp, gap, fr, fb_free, rate;
        r  = '0;
        rp = (32'(cfg_beat) * 32'(it.count)) % RING_BYTES;
        wp = 32'(st.wp);
        // gap and free both read as a full buffer when the pointers meet;
        // with the reader ahead the gap runs past a whole buffer
        if (wp > rp) begin
            gap = wp - rp;
            fr  = RING_BYTES - wp + rp;
        end else if (wp == rp) begin
            gap = RING_BYTES;
            fr  = RING_BYTES;
        end else begin
            gap = RING_BYTES - wp + rp;
            fr  = rp - wp;
        end

        case (it.op)
            OP_PACKET: begin
                if (st.playing) begin
                    if (fr <= 32'(it.len)) begin
                        r.over  = 1'b1;
                        fb_free = 0;
                    end else begin
                        if (gap < 32'(cfg_period) / 2)
                            st.under = 1'b1;
                        else if (gap >= 32'(cfg_period))
                            st.under = 1'b0;
                        st.wp   = WPOS_W'((wp + 32'(it.len)) % RING_BYTES);
                        fb_free = fr;
                        r.free  = FREE_W'(fr > 32'hFFFF ? 32'hFFFF : fr);
                    end
                    if (!it.busy) begin
                        rate = 32'(cfg_nominal);
                        case (st.mode)
                            MODE_NORMAL: begin
                                if (fb_free >= RING_BYTES * 3 / 4)
                                    st.mode = MODE_FAST;
                                else if (fb_free <= RING_BYTES / 4)
                                    st.mode = MODE_SLOW;
                            end
                            MODE_SLOW: begin
                                rate = rate - rate / 8;
                                if (fb_free >= RING_BYTES * 3 / 5)
                                    st.mode = MODE_NORMAL;
                            end
                            MODE_FAST: begin
                                rate = rate + rate / 4;
                                if (fb_free <= RING_BYTES / 2)
                                    st.mode = MODE_NORMAL;
                            end
                            default: ;
                        endcase
                        r.fbv  = 1'b1;
                        r.word = WORD_W'(((rate / 1000) << 14) | ((rate % 1000) << 4));
                    end
                end
            end
            OP_TICK: begin
                if (st.playing && gap < 32'(cfg_period) / 2)
                    st.under = 1'b1;
            end
            OP_START: begin
                st.playing = 1'b1;
                st.wp      = WPOS_W'(32'(cfg_offset) % RING_BYTES);
                st.under   = 1'b0;
                st.mode    = MODE_NORMAL;
            end
            default: begin
                st.playing = 1'b0;
                st.wp      = '0;
                st.under   = 1'b0;
            end
        endcase
        r.under = st.under;
        r.wpos  = st.wp;
        return r;
    endfunction

    function automatic bit steady_window();
        return n_acc >= STEADY_FROM && n_acc < STEADY_TO;
    endfunction

    // DMA beat count that puts the read position a given fill behind the writer
    function automatic logic [COUNT_W-1:0] count_for_fill(input int unsigned fill);
        int unsigned target;
        target = (32'(gen_st.wp) + RING_BYTES - fill % RING_BYTES) % RING_BYTES;
        if (cfg_beat == 0)
            return COUNT_W'($urandom);
        return COUNT_W'(target / 32'(cfg_beat));
    endfunction

    task automatic queue_op(input t_op op, input logic [COUNT_W-1:0] count,
                            input logic [LEN_W-1:0] len, input logic busy);
        ring_item_t   it;
        ring_result_t ignored;
        it.op    = op;
        it.count = count;
        it.len   = len;
        it.busy  = busy;
        ignored  = ring_advance(it, gen_st);
        ring_ops_q.push_back(it);
        n_queued++;
    endtask

    task automatic queue_raw();
        queue_op(t_op'($urandom_range(0, 3)), COUNT_W'($urandom), LEN_W'($urandom),
                 1'($urandom));
    endtask

    // Playback session: fills drift between regions so every rate mode is visited
    task automatic queue_session(input int unsigned n_items);
        int unsigned lo = 0, hi = 0, seg = 0, len, pick, k;
        queue_op(OP_START, COUNT_W'($urandom), LEN_W'($urandom), 1'($urandom));
        for (k = 0; k < n_items; k++) begin
            if (seg == 0) begin
                seg = $urandom_range(8, 40);
                case ($urandom_range(0, 4))
                    0: begin lo = 0;     hi = 32'(cfg_period) + 64; end
                    1: begin lo = 0;     hi = 9000;  end
                    2: begin lo = 8000;  hi = 25000; end
                    3: begin lo = 23000; hi = 32767; end
                    default: begin lo = 30000; hi = 32767; end
                endcase
            end
            seg--;
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(0, 8191);
                1, 2:    len = $urandom_range(0, 4096);
                default: len = $urandom_range(0, 400);
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                // stop, some beats while stopped, then resume
                queue_op(OP_STOP, COUNT_W'($urandom), LEN_W'($urandom), 1'($urandom));
                queue_op(OP_PACKET, COUNT_W'($urandom), LEN_W'(len), 1'($urandom));
                queue_op(OP_TICK, COUNT_W'($urandom), LEN_W'($urandom), 1'($urandom));
                queue_op(OP_START, COUNT_W'($urandom), LEN_W'($urandom), 1'($urandom));
            end else if (pick < 10) begin
                queue_raw();
            end else if (pick < 25) begin
                queue_op(OP_TICK, count_for_fill($urandom_range(lo, hi)), LEN_W'($urandom),
                         1'($urandom));
            end else begin
                queue_op(OP_PACKET, count_for_fill($urandom_range(lo, hi)), LEN_W'(len),
                         $urandom_range(0, 3) == 0);
            end
        end
    endtask

    // Register write; the caller drops the valid after its last write
    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_PERIOD:  cfg_period  = PERIOD_W'(val);
            CFG_BEAT:    cfg_beat    = BEAT_W'(val);
            CFG_NOMINAL: cfg_nominal = RATE_W'(val);
            default:     cfg_offset  = OFFS_W'(val);
        endcase
    endtask

    task automatic wait_drained();
        while (!(n_acc == n_queued && n_chk == n_queued))
            @(posedge clk);
    endtask

    // Event driver: predicts each accepted beat, then offers the next one
    always @(posedge clk) begin : drive
        ring_item_t   cur_op;
        ring_result_t lvl;
        t_mode        mode_then;
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                mode_then = ring_st.mode;
                lvl = ring_advance(cur_op, ring_st);
                level_reports_q.push_back(lvl);
                n_acc <= n_acc + 1;
                n_over  += lvl.over;
                n_under += lvl.under;
                n_fb    += lvl.fbv;
                if (lvl.fbv && mode_then == MODE_SLOW)
                    n_fb_slow++;
                if (lvl.fbv && mode_then == MODE_FAST)
                    n_fb_fast++;
            end
            if (!s_valid || s_ready) begin
                if (ring_ops_q.size() != 0 && (steady_window() || $urandom_range(0, 99) >= 32)) begin
                    cur_op = ring_ops_q.pop_front();
                    s_tdata <= S_TDATA_W'({cur_op.busy, cur_op.len, cur_op.count});
                    s_tuser <= cur_op.op;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, once, so the pipeline backs up into the input
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && n_acc >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: each result beat against the oldest outstanding report
    always @(posedge clk) begin : watch
        ring_result_t got, want;
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = ring_result_t'(m_tdata[$bits(ring_result_t)-1:0]);
                if (n_chk >= n_acc) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("[%0t] result beat with no report outstanding: %h", $realtime,
                                 m_tdata);
                end else begin
                    want = level_reports_q[n_chk];
                    if (got.free !== want.free || got.over !== want.over
                        || got.under !== want.under || got.wpos !== want.wpos
                        || got.fbv !== want.fbv || got.word !== want.word) begin
                        n_err++;
                        if (n_err <= 10)
                            $display({"[%0t] report %0d (exp/got): free %0d/%0d over %0b/%0b",
                                      " under %0b/%0b wpos %0d/%0d fbv %0b/%0b word %h/%h"},
                                     $realtime, n_chk, want.free, got.free, want.over,
                                     got.over, want.under, got.under, want.wpos, got.wpos,
                                     want.fbv, got.fbv, want.word, got.word);
                    end
                    n_chk <= n_chk + 1;
                end
            end
            if (hold_left != 0)
                m_ready <= 1'b0;
            else
                m_ready <= steady_window() || $urandom_range(0, 99) >= 32;
        end
    end

    always @(posedge clk) begin
        n_cyc <= n_cyc + 1;
        if (n_cyc == CYCLE_LIMIT) begin
            $display("timeout: %0d beats in, %0d results checked", n_acc, n_chk);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Settings per phase: reset values, both extremes, odd beat sizes, zero period
    initial begin
        automatic int unsigned set_period  [N_PHASES] = '{192, 0, 8191, 1, 4096, 96, 0, 192};
        automatic int unsigned set_beat    [N_PHASES] = '{2, 1, 4, 7, 3, 0, 0, 2};
        automatic int unsigned set_nominal [N_PHASES] = '{48000, 8000, 192000, 262143, 44100,
                                                          96000, 0, 48000};
        automatic int unsigned set_offset  [N_PHASES] = '{384, 0, 32767, 16384, 1000, 12345,
                                                          0, 384};
        int unsigned ph;
        ring_st = RING_IDLE;
        gen_st  = RING_IDLE;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening under reset register values
        @(negedge clk);
        queue_op(OP_PACKET, 15'd0, 13'd100, 1'b0);               // ignored, not playing
        queue_op(OP_TICK, 15'h7FFF, 13'd0, 1'b0);                // ignored, not playing
        queue_op(OP_STOP, 15'd0, 13'd0, 1'b1);
        queue_op(OP_START, 15'd0, 13'd0, 1'b0);
        queue_op(OP_PACKET, count_for_fill(0), 13'd0, 1'b0);     // pointers meet: full free
        queue_op(OP_PACKET, count_for_fill(10), 13'd50, 1'b0);   // underrun sets
        queue_op(OP_TICK, count_for_fill(50), 13'd0, 1'b0);
        queue_op(OP_PACKET, count_for_fill(200), 13'd100, 1'b0); // underrun clears
        queue_op(OP_PACKET, count_for_fill(32700), 13'h1FFF, 1'b0); // overrun
        queue_op(OP_PACKET, count_for_fill(32000), 13'd4096, 1'b0); // overrun, to slow
        queue_op(OP_PACKET, count_for_fill(16000), 13'd10, 1'b1);   // feedback busy
        queue_op(OP_PACKET, count_for_fill(25000), 13'd0, 1'b0);
        queue_op(OP_PACKET, count_for_fill(1000), 13'd192, 1'b0);   // back to normal
        queue_op(OP_PACKET, 15'h7FFF, 13'd1, 1'b0);
        queue_op(OP_TICK, count_for_fill(0), 13'h1FFF, 1'b1);
        queue_op(OP_PACKET, count_for_fill(0), 13'h1FFF, 1'b0);     // largest chunk fits
        queue_op(OP_PACKET, count_for_fill(100), 13'd0, 1'b0);
        queue_op(OP_STOP, 15'h7FFF, 13'h1FFF, 1'b0);
        queue_op(OP_PACKET, 15'd5, 13'd5, 1'b0);                 // ignored after stop
        queue_op(OP_START, 15'd0, 13'd0, 1'b0);
        @(posedge clk);

        for (ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            repeat (8) @(posedge clk);
            if (ph == 6) begin
                set_period[ph]  = $urandom_range(1, 4096);
                set_beat[ph]    = $urandom_range(1, 4);
                set_nominal[ph] = $urandom_range(8000, 192000);
                set_offset[ph]  = $urandom_range(0, 32767);
            end
            write_reg(CFG_PERIOD, set_period[ph]);
            write_reg(CFG_BEAT, set_beat[ph]);
            write_reg(CFG_NOMINAL, set_nominal[ph]);
            write_reg(CFG_OFFSET, set_offset[ph]);
            cfg_valid <= 1'b0;
            @(negedge clk);
            queue_session(160);
            @(posedge clk);
        end

        wait_drained();
        repeat (20) @(posedge clk);
        $display({"covered %0d event beats over %0d register settings: %0d overruns,",
                  " %0d beats in underrun"}, n_acc, N_PHASES + 1, n_over, n_under);
        $display("feedback words %0d (%0d at low rate, %0d at high rate), %0d mismatches",
                 n_fb, n_fb_slow, n_fb_fast, n_err);
        if (n_err == 0 && n_chk == n_acc) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
